>>> hdl/csm_pkg.sv
// Shared definitions for the contiguous subsequence matcher.
// Holds default sizes, op codes and the per-cell control struct; no dependencies.
package csm_pkg;

    localparam int MAX_PATTERN_DEFAULT = 64;
    localparam int DATA_WIDTH_DEFAULT  = 32;

    // Width of the op and value fields on the item channel.
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    typedef struct packed {
        logic load;
        logic text;
        logic clear;
    } cell_ctrl_t;

endpackage

>>> hdl/csm_cell.sv
// One cell of the matcher chain: a pattern element, its valid bit and its match bit.
// Depends on csm_pkg for the control struct.
module csm_cell #(
    parameter int WIDTH = csm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csm_pkg::cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]    din,
    input  logic                prev_valid,
    input  logic                prev_match,
    input  logic                next_valid,
    output logic                valid,
    output logic                match,
    output logic                hit
);

    logic             valid_reg;
    logic             valid_next;
    logic             match_reg;
    logic             match_next;
    logic [WIDTH-1:0] pat_reg;
    logic             take;
    logic             eq;

    // The load beat goes to the first empty cell: its predecessor is full and it is not.
    assign take = ctrl.load && prev_valid && !valid_reg;
    assign eq   = valid_reg && (pat_reg == din) && prev_match;

    always_comb
    begin
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
            match_next = 1'b0;
        end
        else if (take)
        begin
            valid_next = 1'b1;
            match_next = 1'b0;
        end
        else if (ctrl.text)
        begin
            match_next = eq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pat_reg <= din;
        end
    end

    assign valid = valid_reg;
    assign match = match_reg;
    // A full match ends at the last stored element.
    assign hit   = ctrl.text && eq && !next_valid;

endmodule

>>> hdl/contiguous_subsequence_matcher.sv
// A result is registered and appears in the cycle after its end-of-text beat is accepted.
// Throughput: one item beat per cycle; every cell updates in parallel on each text beat.
// A waiting result holds off the item channel; a new beat is taken in the cycle it leaves.
// Reset (rst_n, asynchronous, active low) clears cell valid and match bits, the flags
// and result_valid; pattern element, found and overflow registers are not reset.
// Depends on csm_pkg and csm_cell.
module contiguous_subsequence_matcher #(
    parameter int MAX_PATTERN = csm_pkg::MAX_PATTERN_DEFAULT,
    parameter int DATA_WIDTH  = csm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [csm_pkg::OP_W-1:0]           op,
    input  logic signed [csm_pkg::VALUE_W-1:0] value,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               found,
    output logic                               overflow
);

    // Only the low DATA_WIDTH bits of a value take part in a compare, and the
    // value field itself carries no more than VALUE_W bits.
    localparam int CMP_W = (DATA_WIDTH < csm_pkg::VALUE_W) ? DATA_WIDTH : csm_pkg::VALUE_W;

    logic                   accept;
    csm_pkg::cell_ctrl_t    ctrl;
    logic [CMP_W-1:0]       din;
    logic [MAX_PATTERN-1:0] cell_valid;
    logic [MAX_PATTERN-1:0] cell_match;
    logic [MAX_PATTERN-1:0] cell_hit;

    logic found_flag_reg;
    logic found_flag_next;
    logic overflow_flag_reg;
    logic overflow_flag_next;
    logic result_valid_reg;
    logic result_valid_next;
    logic found_reg;
    logic overflow_reg;

    // A new beat is taken whenever the output register is empty or is being
    // emptied in this cycle.
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign ctrl.load  = accept && (op == csm_pkg::OP_LOAD);
    assign ctrl.text  = accept && (op == csm_pkg::OP_TEXT);
    assign ctrl.clear = accept && (op == csm_pkg::OP_END);
    assign din        = value[CMP_W-1:0];

    // The chain: cell k takes the match bit of cell k-1 from the previous text
    // beat, so bit k means pattern elements 0..k end at the current text element.
    // Cell 0 sees a permanent match and a full predecessor.
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic prev_valid;
            logic prev_match;
            logic next_valid;

            if (k == 0)
            begin : g_first
                assign prev_valid = 1'b1;
                assign prev_match = 1'b1;
            end
            else
            begin : g_inner
                assign prev_valid = cell_valid[k-1];
                assign prev_match = cell_match[k-1];
            end

            if (k == MAX_PATTERN - 1)
            begin : g_last
                assign next_valid = 1'b0;
            end
            else
            begin : g_body
                assign next_valid = cell_valid[k+1];
            end

            csm_cell #(
                .WIDTH(CMP_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .din       (din),
                .prev_valid(prev_valid),
                .prev_match(prev_match),
                .next_valid(next_valid),
                .valid     (cell_valid[k]),
                .match     (cell_match[k]),
                .hit       (cell_hit[k])
            );
        end
    endgenerate

    // Found latches once the last stored element matches; a load into a full
    // chain is dropped and marks overflow. End of text clears both.
    always_comb
    begin
        found_flag_next    = found_flag_reg;
        overflow_flag_next = overflow_flag_reg;
        if (ctrl.clear)
        begin
            found_flag_next    = 1'b0;
            overflow_flag_next = 1'b0;
        end
        else
        begin
            if (|cell_hit)
            begin
                found_flag_next = 1'b1;
            end
            if (ctrl.load && cell_valid[MAX_PATTERN-1])
            begin
                overflow_flag_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (ctrl.clear)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_flag_reg    <= 1'b0;
            overflow_flag_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            found_flag_reg    <= found_flag_next;
            overflow_flag_reg <= overflow_flag_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // An empty pattern (cell 0 not valid) always counts as found.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            found_reg    <= !cell_valid[0] || found_flag_reg;
            overflow_reg <= overflow_flag_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign overflow     = overflow_reg;

endmodule

>>> hdl/csm_checker.sv
// Port-level assertions for the contiguous subsequence matcher, bound to the top level.
// Depends on csm_pkg for op codes.
module csm_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_ready,
    input logic [csm_pkg::OP_W-1:0] op,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic                     found,
    input logic                     overflow
);

    logic end_beat;

    assign end_beat = item_valid && item_ready && (op == csm_pkg::OP_END);

    // A waiting result holds its beat.
    a_result_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(found) && $stable(overflow))
        else $error("result beat changed while stalled");

    // Every newly raised result comes from an end-of-text beat in the cycle before.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(end_beat))
        else $error("result appeared without an end-of-text beat");

    a_end_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        end_beat |=> result_valid)
        else $error("end-of-text beat gave no result");

    // Back-to-back end beats: the second sees an empty pattern.
    a_empty_pair : assert property (@(posedge clk) disable iff (!rst_n)
        end_beat ##1 end_beat |=> result_valid && found && !overflow)
        else $error("empty pattern did not report found without overflow");

    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item channel stalled with empty output register");

endmodule

bind contiguous_subsequence_matcher csm_checker u_csm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .op          (op),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .found       (found),
    .overflow    (overflow)
);
